// File: rtl/pfca_pkg.sv
package pfca_pkg;

	localparam int MaxFrames = 1024;
	localparam int FrameBits = $clog2(MaxFrames);
	localparam int CountBits = 11;
	localparam int OwnerBits = 8;
	localparam int VpageBits = 20;
	localparam int EntryBits = 2 + OwnerBits + VpageBits + CountBits;

	localparam logic [VpageBits-1:0] KsegVpage = 20'h80000;

	typedef enum logic [1:0] {
		ST_FIXED = 2'd0,
		ST_FREE  = 2'd1,
		ST_USED  = 2'd2
	} frame_state_t;

	typedef enum logic [2:0] {
		OP_INIT        = 3'd0,
		OP_ALLOC_KERN  = 3'd1,
		OP_ALLOC_USER  = 3'd2,
		OP_FREE_KERN   = 3'd3,
		OP_FREE_USER   = 3'd4
	} op_t;

	localparam logic CFG_TOTAL    = 1'b0;
	localparam logic CFG_RESERVED = 1'b1;

	typedef struct packed {
		logic [1:0]           state;
		logic [OwnerBits-1:0] owner;
		logic [VpageBits-1:0] vpage;
		logic [CountBits-1:0] run;
	} entry_t;

	typedef struct packed {
		logic                 rd_en;
		logic                 wr_en;
		logic [FrameBits-1:0] addr;
		entry_t               wdata;
	} pfca_cmd_t;

	typedef struct packed {
		logic   rd_valid;
		entry_t rdata;
	} pfca_sts_t;

endpackage

// File: rtl/pfca_if.sv
interface pfca_in_if;
	import pfca_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [2:0]           operation;
	logic [CountBits-1:0] page_count;
	logic [OwnerBits-1:0] owner;
	logic [VpageBits-1:0] page_number;
	modport source (output valid, operation, page_count, owner, page_number, input ready);
	modport sink (input valid, operation, page_count, owner, page_number, output ready);
endinterface

interface pfca_out_if;
	import pfca_pkg::*;
	logic                 valid;
	logic                 ready;
	logic                 found;
	logic [FrameBits-1:0] frame;
	logic [CountBits-1:0] freed_count;
	modport source (output valid, found, frame, freed_count, input ready);
	modport sink (input valid, found, frame, freed_count, output ready);
endinterface

interface pfca_cfg_if;
	import pfca_pkg::*;
	logic                 valid;
	logic                 ready;
	logic                 index;
	logic [CountBits-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/pfca_ram.sv
module pfca_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(Depth)-1:0] wr_addr,
	input  logic [Width-1:0]         wr_data,
	input  logic [$clog2(Depth)-1:0] rd_addr,
	output logic [Width-1:0]         rd_data
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end
endmodule

// File: rtl/pfca_datapath.sv
module pfca_datapath
	import pfca_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  pfca_cmd_t cmd,
	output pfca_sts_t sts
);
	logic [EntryBits-1:0] rd_raw;
	logic                 rd_q;

	pfca_ram #(.Width(EntryBits), .Depth(MaxFrames)) u_ram (
		.clk     (clk),
		.wr_en   (cmd.wr_en),
		.wr_addr (cmd.addr),
		.wr_data (cmd.wdata),
		.rd_addr (cmd.addr),
		.rd_data (rd_raw)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0;
		end else begin
			rd_q <= cmd.rd_en;
		end
	end

	assign sts.rd_valid = rd_q;
	assign sts.rdata    = entry_t'(rd_raw);
endmodule

// File: rtl/pfca_ctrl.sv
module pfca_ctrl
	import pfca_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [2:0]           operation,
	input  logic [CountBits-1:0] page_count,
	input  logic [OwnerBits-1:0] owner,
	input  logic [VpageBits-1:0] page_number,
	input  logic [CountBits-1:0] total_pages,
	input  logic [CountBits-1:0] reserved_pages,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 found,
	output logic [FrameBits-1:0] frame,
	output logic [CountBits-1:0] freed_count,
	output pfca_cmd_t            cmd,
	input  pfca_sts_t            sts
);
	typedef enum logic [2:0] {
		S_IDLE, S_INIT, S_READ, S_WAIT, S_WRITE, S_DONE
	} state_t;

	localparam logic [CountBits-1:0] MaxN = CountBits'(MaxFrames);

	state_t               state_q;
	logic [2:0]           op_q;
	logic [CountBits-1:0] count_q, owner_n, n_q, r_q;
	logic [OwnerBits-1:0] owner_q;
	logic [VpageBits-1:0] page_q;
	logic [CountBits-1:0] idx_q;
	logic [CountBits-1:0] base_q;
	logic [CountBits-1:0] left_q;
	logic [CountBits-1:0] freed_q;
	logic                 found_q;
	logic [CountBits-1:0] n_c, r_c;
	logic [CountBits:0]   end_c;

	assign owner_n = '0;
	assign n_c = (total_pages > MaxN) ? MaxN : total_pages;
	assign r_c = (reserved_pages > n_c) ? n_c : reserved_pages;
	assign end_c = {1'b0, base_q} + {1'b0, count_q};

	assign in_ready    = (state_q == S_IDLE) && !out_valid;
	assign found       = found_q;
	assign freed_count = freed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_valid <= 1'b0;
			cmd       <= '0;
			op_q      <= '0;
			count_q   <= '0;
			owner_q   <= '0;
			page_q    <= '0;
			n_q       <= '0;
			r_q       <= '0;
			idx_q     <= '0;
			base_q    <= '0;
			left_q    <= '0;
			freed_q   <= '0;
			found_q   <= 1'b0;
			frame     <= '0;
		end else begin
			cmd.rd_en <= 1'b0;
			cmd.wr_en <= 1'b0;
			if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						op_q    <= operation;
						count_q <= page_count;
						owner_q <= owner;
						page_q  <= page_number;
						n_q     <= n_c;
						r_q     <= r_c;
						idx_q   <= '0;
						base_q  <= '0;
						left_q  <= '0;
						freed_q <= '0;
						found_q <= 1'b0;
						frame   <= '0;
						case (operation)
							OP_INIT:       state_q <= S_INIT;
							OP_ALLOC_KERN: state_q <= (page_count == '0) ? S_DONE : S_READ;
							OP_ALLOC_USER, OP_FREE_KERN: state_q <= S_READ;
							OP_FREE_USER: begin
								if ({{(VpageBits-CountBits){1'b0}}, n_c} > page_number) begin
									idx_q   <= page_number[CountBits-1:0];
									state_q <= S_READ;
								end else begin
									state_q <= S_DONE;
								end
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_INIT: begin
					if (idx_q >= n_q) begin
						state_q <= S_DONE;
					end else begin
						cmd.wr_en       <= 1'b1;
						cmd.addr        <= idx_q[FrameBits-1:0];
						cmd.wdata.owner <= '0;
						cmd.wdata.run   <= CountBits'(1);
						if (idx_q < r_q) begin
							cmd.wdata.state <= ST_FIXED;
							cmd.wdata.vpage <= KsegVpage + VpageBits'(idx_q);
						end else begin
							cmd.wdata.state <= ST_FREE;
							cmd.wdata.vpage <= '0;
						end
						idx_q <= idx_q + 1'b1;
					end
				end
				S_READ: begin
					if (idx_q >= n_q || (op_q == OP_ALLOC_KERN && end_c > {1'b0, n_q})) begin
						state_q <= S_DONE;
					end else begin
						cmd.rd_en <= 1'b1;
						cmd.addr  <= idx_q[FrameBits-1:0];
						state_q   <= S_WAIT;
					end
				end
				S_WAIT: begin
					if (sts.rd_valid) begin
						state_q <= S_READ;
						case (op_q)
							OP_ALLOC_KERN: begin
								if (sts.rdata.state != ST_FREE) begin
									base_q <= idx_q + 1'b1;
									idx_q  <= idx_q + 1'b1;
								end else if (idx_q + 1'b1 == end_c[CountBits-1:0]) begin
									found_q <= 1'b1;
									frame   <= base_q[FrameBits-1:0];
									idx_q   <= base_q;
									state_q <= S_WRITE;
								end else begin
									idx_q <= idx_q + 1'b1;
								end
							end
							OP_ALLOC_USER: begin
								if (sts.rdata.state == ST_FREE) begin
									found_q         <= 1'b1;
									frame           <= idx_q[FrameBits-1:0];
									cmd.wr_en       <= 1'b1;
									cmd.wdata.state <= ST_USED;
									cmd.wdata.owner <= owner_q;
									cmd.wdata.vpage <= page_q;
									cmd.wdata.run   <= CountBits'(1);
									state_q         <= S_DONE;
								end else begin
									idx_q <= idx_q + 1'b1;
								end
							end
							OP_FREE_KERN: begin
								if (left_q != '0) begin
									cmd.wr_en       <= 1'b1;
									cmd.wdata.state <= ST_FREE;
									cmd.wdata.owner <= '0;
									cmd.wdata.vpage <= '0;
									cmd.wdata.run   <= CountBits'(1);
									freed_q <= freed_q +
										CountBits'(sts.rdata.state != ST_FREE);
									left_q <= left_q - 1'b1;
								end else if (sts.rdata.vpage == page_q &&
									sts.rdata.owner == '0) begin
									found_q <= 1'b1;
									if (sts.rdata.run != '0) begin
										cmd.wr_en       <= 1'b1;
										cmd.wdata.state <= ST_FREE;
										cmd.wdata.owner <= '0;
										cmd.wdata.vpage <= '0;
										cmd.wdata.run   <= CountBits'(1);
										freed_q <= freed_q +
											CountBits'(sts.rdata.state != ST_FREE);
										left_q  <= sts.rdata.run - 1'b1;
									end
								end
								idx_q <= idx_q + 1'b1;
							end
							default: begin
								found_q         <= 1'b1;
								freed_q         <= CountBits'(sts.rdata.state != ST_FREE);
								cmd.wr_en       <= 1'b1;
								cmd.wdata.state <= ST_FREE;
								cmd.wdata.owner <= '0;
								cmd.wdata.vpage <= '0;
								cmd.wdata.run   <= CountBits'(1);
								state_q         <= S_DONE;
							end
						endcase
					end
				end
				S_WRITE: begin
					if (idx_q == end_c[CountBits-1:0]) begin
						state_q <= S_DONE;
					end else begin
						cmd.wr_en       <= 1'b1;
						cmd.addr        <= idx_q[FrameBits-1:0];
						cmd.wdata.state <= ST_USED;
						cmd.wdata.owner <= owner_n[OwnerBits-1:0];
						cmd.wdata.vpage <= KsegVpage + VpageBits'(base_q);
						cmd.wdata.run   <= end_c[CountBits-1:0] - idx_q;
						idx_q           <= idx_q + 1'b1;
					end
				end
				S_DONE: begin
					if (!out_valid) begin
						out_valid <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// File: rtl/page_frame_coremap_allocator.sv
// With n the managed frame count (total_pages clamped to 1024): init writes its n entries and
// then presents its word; the other operations read up to n frames of the core map through
// the single RAM read port, one read in flight at a time, and a successful kernel allocation
// then writes its run of page_count entries before the result word.
// Throughput: one operation at a time; the next is accepted after the result word is taken.
// Reset clears the controller and loads total_pages = 1024, reserved_pages = 16;
module page_frame_coremap_allocator
	import pfca_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	pfca_in_if.sink   in_ch,
	pfca_out_if.source out_ch,
	pfca_cfg_if.sink  cfg
);
	pfca_cmd_t            cmd;
	pfca_sts_t            sts;
	logic [CountBits-1:0] total_q, reserved_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q    <= CountBits'(1024);
			reserved_q <= CountBits'(16);
		end else if (cfg.valid) begin
			if (cfg.index == CFG_TOTAL) begin
				total_q <= cfg.data;
			end else begin
				reserved_q <= cfg.data;
			end
		end
	end

	pfca_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_ch.valid),
		.in_ready       (in_ch.ready),
		.operation      (in_ch.operation),
		.page_count     (in_ch.page_count),
		.owner          (in_ch.owner),
		.page_number    (in_ch.page_number),
		.total_pages    (total_q),
		.reserved_pages (reserved_q),
		.out_valid      (out_ch.valid),
		.out_ready      (out_ch.ready),
		.found          (out_ch.found),
		.frame          (out_ch.frame),
		.freed_count    (out_ch.freed_count),
		.cmd            (cmd),
		.sts            (sts)
	);

	pfca_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sts    (sts)
	);

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> !in_ch.ready) else $error("input taken while result pending");
	a_rd_follow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |=> sts.rd_valid) else $error("read data not flagged");
	a_frame_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !out_ch.found) |-> out_ch.frame == '0) else $error("frame not zero");
endmodule
